// ----- rtl/core/range_affine_update_sum_tree_core_defines.svh -----
// Assertion macros for the range affine update sum tree core.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef RANGE_AFFINE_UPDATE_SUM_TREE_CORE_DEFINES_SVH
`define RANGE_AFFINE_UPDATE_SUM_TREE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LSAT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LSAT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/lsat_pkg.sv -----
// Shared types, constants and codes of the range affine update sum tree core.
// No dependencies.
package lsat_pkg;

  localparam int LEAVES     = 1024;
  localparam int FRAC_BITS  = 24;
  localparam int NODE_DEPTH = 2 * LEAVES;
  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  localparam int LEAF_AW    = 10;
  localparam int LC_W       = 11;
  localparam int STK_DEPTH  = 16;
  localparam int STK_AW     = $clog2(STK_DEPTH);
  localparam int ACC_W      = 64 + FRAC_BITS;

  localparam logic [63:0] FIX_ONE = 64'd1 << FRAC_BITS;

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_MUL   = 2'd1;
  localparam logic [1:0] OP_ADD   = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  // Memory write kinds.
  localparam logic [2:0] WR_RESET = 3'd0;
  localparam logic [2:0] WR_APPLY = 3'd1;
  localparam logic [2:0] WR_CLEAN = 3'd2;
  localparam logic [2:0] WR_LEAF  = 3'd3;
  localparam logic [2:0] WR_PULL  = 3'd4;

  // Multiply steps of one tag application.
  localparam logic [1:0] MK_TOTAL  = 2'd0;
  localparam logic [1:0] MK_LEN    = 2'd1;
  localparam logic [1:0] MK_ADDEND = 2'd2;
  localparam logic [1:0] MK_FACTOR = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [LEAF_AW-1:0] range_first;
    logic [LEAF_AW-1:0] range_last;
    logic signed [63:0] operand_value;
  } lsat_in_t;

  typedef struct packed {
    logic signed [63:0] range_total;
    logic               range_error;
  } lsat_out_t;

  typedef struct packed {
    logic [63:0] total;
    logic [63:0] addend;
    logic [63:0] factor;
  } lsat_word_t;

  typedef struct packed {
    logic               in_load;
    logic               rd;
    logic               latch;
    logic               wr;
    logic [2:0]         wr_sel;
    logic [NODE_AW-1:0] addr;
    logic               tag_op;
    logic               tag_word;
    logic               mul_go;
    logic [1:0]         mul_k;
    logic [LC_W-1:0]    len;
    logic               acc_add;
    logic               lsum_load;
  } lsat_cmd_t;

  typedef struct packed {
    logic mul_done;
  } lsat_stat_t;

endpackage

// ----- rtl/core/lsat_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/lsat_fxmul.sv -----
// Sequential signed 64x64 multiplier from four 33x33 partial products.
// Gives the fixed-point product or the plain low word. Depends on lsat_pkg.
module lsat_fxmul import lsat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic        frac,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] res
);

  logic [63:0]        a_r, b_r;
  logic               frac_r;
  logic [2:0]         cnt_r;
  logic               run_r;
  logic signed [65:0] pp_r;
  logic               ppv_r;
  logic [1:0]         sh_r;
  logic [ACC_W-1:0]   acc_r;
  logic               done_r;

  logic signed [32:0] opa, opb;
  logic signed [65:0] prod;
  logic [1:0]         sh_nxt;
  logic [ACC_W-1:0]   pp_ext, pp_sh;

  always_comb begin
    case (cnt_r[1:0])
      2'd0: begin
        opa = $signed({1'b0, a_r[31:0]});
        opb = $signed({1'b0, b_r[31:0]});
        sh_nxt = 2'd0;
      end
      2'd1: begin
        opa = $signed({1'b0, a_r[31:0]});
        opb = $signed({b_r[63], b_r[63:32]});
        sh_nxt = 2'd1;
      end
      2'd2: begin
        opa = $signed({a_r[63], a_r[63:32]});
        opb = $signed({1'b0, b_r[31:0]});
        sh_nxt = 2'd1;
      end
      default: begin
        opa = $signed({a_r[63], a_r[63:32]});
        opb = $signed({b_r[63], b_r[63:32]});
        sh_nxt = 2'd2;
      end
    endcase
    prod   = opa * opb;
    pp_ext = {{(ACC_W-66){pp_r[65]}}, pp_r};
    case (sh_r)
      2'd0:    pp_sh = pp_ext;
      2'd1:    pp_sh = pp_ext << 32;
      default: pp_sh = pp_ext << 64;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      ppv_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= !go && run_r && (cnt_r == 3'd4) && ppv_r;
      if (go) begin
        a_r    <= a;
        b_r    <= b;
        frac_r <= frac;
        cnt_r  <= 3'd0;
        run_r  <= 1'b1;
        ppv_r  <= 1'b0;
        acc_r  <= '0;
      end else if (run_r) begin
        if (cnt_r < 3'd4) begin
          pp_r  <= prod;
          sh_r  <= sh_nxt;
          ppv_r <= 1'b1;
          cnt_r <= cnt_r + 3'd1;
        end else begin
          ppv_r <= 1'b0;
        end
        if (ppv_r) begin
          acc_r <= acc_r + pp_sh;
        end
        if (cnt_r == 3'd4 && ppv_r) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = frac_r ? acc_r[FRAC_BITS +: 64] : acc_r[63:0];

endmodule

// ----- rtl/core/lsat_dp.sv -----
// Datapath: node memory, tag registers, multiplier and the sum accumulator.
// Depends on lsat_pkg, lsat_ram and lsat_fxmul.
module lsat_dp import lsat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  lsat_in_t    in_data,
  input  lsat_cmd_t   cmd,
  output lsat_stat_t  stat,
  output logic [63:0] total
);

  lsat_word_t  word_r, rdata, wdata;
  logic [63:0] tf_r, ta_r, ptot_r, lsum_r, acc_r;
  logic [63:0] nt_r, lm_r, na_r, nf_r, v_r;
  logic [1:0]  op_r, k_r;
  logic [63:0] mul_a, mul_b, mul_res;
  logic        mul_frac, mul_done;

  lsat_ram #(.WIDTH($bits(lsat_word_t)), .DEPTH(NODE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.wr),
    .waddr (cmd.addr),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (cmd.addr),
    .rdata (rdata)
  );

  always_comb begin
    mul_b    = tf_r;
    mul_frac = 1'b1;
    case (cmd.mul_k)
      MK_TOTAL:  mul_a = word_r.total;
      MK_LEN: begin
        mul_a    = 64'(cmd.len);
        mul_b    = ta_r;
        mul_frac = 1'b0;
      end
      MK_ADDEND: mul_a = word_r.addend;
      default:   mul_a = word_r.factor;
    endcase
  end

  lsat_fxmul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.mul_go),
    .frac  (mul_frac),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  always_comb begin
    case (cmd.wr_sel)
      WR_APPLY: wdata = '{total: nt_r + lm_r, addend: na_r + ta_r, factor: nf_r};
      WR_CLEAN: wdata = '{total: ptot_r, addend: 64'd0, factor: FIX_ONE};
      WR_LEAF:  wdata = '{total: v_r, addend: 64'd0, factor: FIX_ONE};
      WR_PULL:  wdata = '{total: lsum_r + word_r.total, addend: 64'd0, factor: FIX_ONE};
      default:  wdata = '{total: 64'd0, addend: 64'd0, factor: FIX_ONE};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_r  <= in_data.operation;
      v_r   <= in_data.operand_value;
      acc_r <= 64'd0;
    end
    if (cmd.latch) begin
      word_r <= rdata;
    end
    if (cmd.tag_op) begin
      if (op_r == OP_MUL) begin
        tf_r <= v_r;
        ta_r <= 64'd0;
      end else begin
        tf_r <= FIX_ONE;
        ta_r <= v_r;
      end
    end
    if (cmd.tag_word) begin
      tf_r   <= word_r.factor;
      ta_r   <= word_r.addend;
      ptot_r <= word_r.total;
    end
    if (cmd.mul_go) begin
      k_r <= cmd.mul_k;
    end
    if (mul_done) begin
      case (k_r)
        MK_TOTAL:  nt_r <= mul_res;
        MK_LEN:    lm_r <= mul_res;
        MK_ADDEND: na_r <= mul_res;
        default:   nf_r <= mul_res;
      endcase
    end
    if (cmd.acc_add) begin
      acc_r <= acc_r + word_r.total;
    end
    if (cmd.lsum_load) begin
      lsum_r <= word_r.total;
    end
  end

  assign stat.mul_done = mul_done;
  assign total         = acc_r;

endmodule

// ----- rtl/core/lsat_ctrl.sv -----
// Controller: range check, tree walk with an explicit frame stack, clearing pass.
// Drives the datapath by command words. Depends on lsat_pkg.
module lsat_ctrl import lsat_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  lsat_in_t         in_data,
  input  logic             cfg_we,
  input  logic [LC_W-1:0]  cfg_wdata,
  input  lsat_stat_t       stat,
  output lsat_cmd_t        cmd,
  output logic             busy,
  output logic             out_valid,
  output logic             range_error
);

  localparam logic [4:0] S_CLR     = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_CHECK   = 5'd2;
  localparam logic [4:0] S_VISIT   = 5'd3;
  localparam logic [4:0] S_AP_RD   = 5'd4;
  localparam logic [4:0] S_AP_LAT  = 5'd5;
  localparam logic [4:0] S_AP_GO   = 5'd6;
  localparam logic [4:0] S_AP_WAIT = 5'd7;
  localparam logic [4:0] S_AP_WR   = 5'd8;
  localparam logic [4:0] S_PD_RD   = 5'd9;
  localparam logic [4:0] S_PD_LAT  = 5'd10;
  localparam logic [4:0] S_PD_TAG  = 5'd11;
  localparam logic [4:0] S_PD_CLN  = 5'd12;
  localparam logic [4:0] S_CHL     = 5'd13;
  localparam logic [4:0] S_CHR     = 5'd14;
  localparam logic [4:0] S_FIN     = 5'd15;
  localparam logic [4:0] S_PU_RDL  = 5'd16;
  localparam logic [4:0] S_PU_LATL = 5'd17;
  localparam logic [4:0] S_PU_RDR  = 5'd18;
  localparam logic [4:0] S_PU_LATR = 5'd19;
  localparam logic [4:0] S_PU_WR   = 5'd20;
  localparam logic [4:0] S_Q_RD    = 5'd21;
  localparam logic [4:0] S_Q_LAT   = 5'd22;
  localparam logic [4:0] S_Q_ACC   = 5'd23;
  localparam logic [4:0] S_LEAF_WR = 5'd24;
  localparam logic [4:0] S_POP     = 5'd25;
  localparam logic [4:0] S_DONE    = 5'd26;

  localparam logic [1:0] RET_POP = 2'd0;
  localparam logic [1:0] RET_PDR = 2'd1;
  localparam logic [1:0] RET_CLN = 2'd2;

  logic [4:0]         state_r, state_nxt;
  logic [LC_W-1:0]    lc_r, lc_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [LEAF_AW-1:0] first_r, first_nxt, last_r, last_nxt;
  logic               err_r, err_nxt;
  logic [NODE_AW-1:0] cur_i_r, cur_i_nxt;
  logic [LEAF_AW-1:0] cur_l_r, cur_l_nxt, cur_h_r, cur_h_nxt;
  logic [STK_AW-1:0]  sp_r, sp_nxt;
  logic [NODE_AW-1:0] ap_addr_r, ap_addr_nxt;
  logic [LC_W-1:0]    ap_len_r, ap_len_nxt;
  logic [1:0]         ap_ret_r, ap_ret_nxt;
  logic [1:0]         mk_r, mk_nxt;
  logic [NODE_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [NODE_AW-1:0] stk_i [STK_DEPTH];
  logic [LEAF_AW-1:0] stk_l [STK_DEPTH];
  logic [LEAF_AW-1:0] stk_h [STK_DEPTH];
  logic               stk_ph [STK_DEPTH];
  logic               push, push_ph;

  logic [LC_W-1:0]    mid_sum;
  logic [LEAF_AW-1:0] mid;
  logic [NODE_AW-1:0] left_i, right_i;
  logic [LC_W-1:0]    len_full, len_l, len_h;
  logic               covered, bad;
  logic [LC_W-1:0]    cfg_clamped;
  logic [STK_AW-1:0]  sp_top;

  always_comb begin
    mid_sum  = {1'b0, cur_l_r} + {1'b0, cur_h_r};
    mid      = mid_sum[LC_W-1:1];
    left_i   = {cur_i_r[NODE_AW-2:0], 1'b0};
    right_i  = {cur_i_r[NODE_AW-2:0], 1'b1};
    len_full = {1'b0, cur_h_r} - {1'b0, cur_l_r} + LC_W'(1);
    len_l    = {1'b0, mid} - {1'b0, cur_l_r} + LC_W'(1);
    len_h    = {1'b0, cur_h_r} - {1'b0, mid};
    covered  = (first_r <= cur_l_r) && (cur_h_r <= last_r);
    sp_top   = sp_r - STK_AW'(1);
    if (op_r == OP_SET) begin
      bad = {1'b0, first_r} >= lc_r;
    end else begin
      bad = (first_r > last_r) || ({1'b0, last_r} >= lc_r);
    end
    if (cfg_wdata == '0) begin
      cfg_clamped = LC_W'(1);
    end else if (cfg_wdata > LC_W'(LEAVES)) begin
      cfg_clamped = LC_W'(LEAVES);
    end else begin
      cfg_clamped = cfg_wdata;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    lc_nxt      = lc_r;
    op_nxt      = op_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    err_nxt     = err_r;
    cur_i_nxt   = cur_i_r;
    cur_l_nxt   = cur_l_r;
    cur_h_nxt   = cur_h_r;
    sp_nxt      = sp_r;
    ap_addr_nxt = ap_addr_r;
    ap_len_nxt  = ap_len_r;
    ap_ret_nxt  = ap_ret_r;
    mk_nxt      = mk_r;
    clr_cnt_nxt = clr_cnt_r;
    push        = 1'b0;
    push_ph     = 1'b0;
    cmd         = '0;
    cmd.addr    = cur_i_r;
    cmd.len     = ap_len_r;
    cmd.mul_k   = mk_r;
    out_valid   = 1'b0;

    case (state_r)
      S_CLR: begin
        cmd.wr      = 1'b1;
        cmd.wr_sel  = WR_RESET;
        cmd.addr    = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + NODE_AW'(1);
        if (clr_cnt_r == NODE_AW'(NODE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.in_load = 1'b1;
          op_nxt      = in_data.operation;
          first_nxt   = in_data.range_first;
          last_nxt    = in_data.range_last;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        err_nxt   = bad;
        // a set walks as a one-leaf range
        if (op_r == OP_SET) begin
          last_nxt = first_r;
        end
        cur_i_nxt = NODE_AW'(1);
        cur_l_nxt = '0;
        cur_h_nxt = LEAF_AW'(lc_r - LC_W'(1));
        sp_nxt    = '0;
        state_nxt = bad ? S_DONE : S_VISIT;
      end
      S_VISIT: begin
        if (covered) begin
          case (op_r)
            OP_QUERY: state_nxt = S_Q_RD;
            OP_SET:   state_nxt = S_LEAF_WR;
            default: begin
              cmd.tag_op  = 1'b1;
              ap_addr_nxt = cur_i_r;
              ap_len_nxt  = len_full;
              ap_ret_nxt  = RET_POP;
              mk_nxt      = MK_TOTAL;
              state_nxt   = S_AP_RD;
            end
          endcase
        end else begin
          state_nxt = S_PD_RD;
        end
      end
      S_AP_RD: begin
        cmd.rd    = 1'b1;
        cmd.addr  = ap_addr_r;
        state_nxt = S_AP_LAT;
      end
      S_AP_LAT: begin
        cmd.latch = 1'b1;
        state_nxt = S_AP_GO;
      end
      S_AP_GO: begin
        cmd.mul_go = 1'b1;
        state_nxt  = S_AP_WAIT;
      end
      S_AP_WAIT: begin
        if (stat.mul_done) begin
          if (mk_r == MK_FACTOR) begin
            state_nxt = S_AP_WR;
          end else begin
            mk_nxt    = mk_r + 2'd1;
            state_nxt = S_AP_GO;
          end
        end
      end
      S_AP_WR: begin
        cmd.wr     = 1'b1;
        cmd.wr_sel = WR_APPLY;
        cmd.addr   = ap_addr_r;
        case (ap_ret_r)
          RET_PDR: begin
            ap_addr_nxt = right_i;
            ap_len_nxt  = len_h;
            ap_ret_nxt  = RET_CLN;
            mk_nxt      = MK_TOTAL;
            state_nxt   = S_AP_RD;
          end
          RET_CLN: state_nxt = S_PD_CLN;
          default: state_nxt = S_POP;
        endcase
      end
      S_PD_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_PD_LAT;
      end
      S_PD_LAT: begin
        cmd.latch = 1'b1;
        state_nxt = S_PD_TAG;
      end
      S_PD_TAG: begin
        cmd.tag_word = 1'b1;
        ap_addr_nxt  = left_i;
        ap_len_nxt   = len_l;
        ap_ret_nxt   = RET_PDR;
        mk_nxt       = MK_TOTAL;
        state_nxt    = S_AP_RD;
      end
      S_PD_CLN: begin
        cmd.wr     = 1'b1;
        cmd.wr_sel = WR_CLEAN;
        state_nxt  = S_CHL;
      end
      S_CHL: begin
        if (first_r <= mid) begin
          push      = 1'b1;
          push_ph   = 1'b0;
          sp_nxt    = sp_r + STK_AW'(1);
          cur_i_nxt = left_i;
          cur_h_nxt = mid;
          state_nxt = S_VISIT;
        end else begin
          state_nxt = S_CHR;
        end
      end
      S_CHR: begin
        if (last_r > mid) begin
          push      = 1'b1;
          push_ph   = 1'b1;
          sp_nxt    = sp_r + STK_AW'(1);
          cur_i_nxt = right_i;
          cur_l_nxt = mid + LEAF_AW'(1);
          state_nxt = S_VISIT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = (op_r == OP_QUERY) ? S_POP : S_PU_RDL;
      end
      S_PU_RDL: begin
        cmd.rd    = 1'b1;
        cmd.addr  = left_i;
        state_nxt = S_PU_LATL;
      end
      S_PU_LATL: begin
        cmd.latch = 1'b1;
        state_nxt = S_PU_RDR;
      end
      S_PU_RDR: begin
        cmd.rd        = 1'b1;
        cmd.addr      = right_i;
        cmd.lsum_load = 1'b1;
        state_nxt     = S_PU_LATR;
      end
      S_PU_LATR: begin
        cmd.latch = 1'b1;
        state_nxt = S_PU_WR;
      end
      S_PU_WR: begin
        cmd.wr     = 1'b1;
        cmd.wr_sel = WR_PULL;
        state_nxt  = S_POP;
      end
      S_Q_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_Q_LAT;
      end
      S_Q_LAT: begin
        cmd.latch = 1'b1;
        state_nxt = S_Q_ACC;
      end
      S_Q_ACC: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_POP;
      end
      S_LEAF_WR: begin
        cmd.wr     = 1'b1;
        cmd.wr_sel = WR_LEAF;
        state_nxt  = S_POP;
      end
      S_POP: begin
        if (sp_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          // resume the parent after the child just finished
          sp_nxt    = sp_top;
          cur_i_nxt = stk_i[sp_top];
          cur_l_nxt = stk_l[sp_top];
          cur_h_nxt = stk_h[sp_top];
          state_nxt = stk_ph[sp_top] ? S_FIN : S_CHR;
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // new shape: restart the clearing pass
    if (cfg_we) begin
      lc_nxt      = cfg_clamped;
      clr_cnt_nxt = '0;
      state_nxt   = S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
      lc_r      <= LC_W'(LEAVES);
      sp_r      <= '0;
      mk_r      <= MK_TOTAL;
      ap_ret_r  <= RET_POP;
      err_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      lc_r      <= lc_nxt;
      sp_r      <= sp_nxt;
      mk_r      <= mk_nxt;
      ap_ret_r  <= ap_ret_nxt;
      err_r     <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    first_r   <= first_nxt;
    last_r    <= last_nxt;
    cur_i_r   <= cur_i_nxt;
    cur_l_r   <= cur_l_nxt;
    cur_h_r   <= cur_h_nxt;
    ap_addr_r <= ap_addr_nxt;
    ap_len_r  <= ap_len_nxt;
    if (push) begin
      stk_i[sp_r]  <= cur_i_r;
      stk_l[sp_r]  <= cur_l_r;
      stk_h[sp_r]  <= cur_h_r;
      stk_ph[sp_r] <= push_ph;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign range_error = err_r;

endmodule

// ----- rtl/core/range_affine_update_sum_tree_core.sv -----
// Lazy segment tree over up to 1024 Q40.24 values: set leaf, range multiply,
// range add and range sum. Start is taken when busy is low; every word gives
// exactly one result strobe on out_valid, one cycle wide, unless a leaf_count
// write restarts the clearing pass first, and the receiver cannot stall it. A
// bad range goes from the check state straight to the done state and strobe,
// and the next start can be taken in the cycle after the strobe. Otherwise the
// walk visits each touched node in turn through one node memory port and one
// shared multiplier: a covered update node is read and put through the four
// tag multiplies, a pushed-down node hands its tags to both children and is
// cleaned, and a pull-up writes the sum of both children. After reset and
// after each leaf_count write, a clearing pass over all 2048 node words holds
// busy high. Depends on lsat_pkg, lsat_ctrl, lsat_dp and the defines header.
`include "range_affine_update_sum_tree_core_defines.svh"

module range_affine_update_sum_tree_core import lsat_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  lsat_in_t        in_data,
  output logic            out_valid,
  output lsat_out_t       out_data,
  input  logic            cfg_we,
  input  logic [LC_W-1:0] cfg_wdata
);

  lsat_cmd_t   cmd;
  lsat_stat_t  stat;
  logic [63:0] total;
  logic        range_error;

  lsat_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_data     (in_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy),
    .out_valid   (out_valid),
    .range_error (range_error)
  );

  lsat_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .total   (total)
  );

  assign out_data.range_total = total;
  assign out_data.range_error = range_error;

  `LSAT_ASSERT_IMP(a_strobe_busy, out_valid, busy, "result strobe outside a busy item")
  `LSAT_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
  `LSAT_ASSERT_NXT(a_one_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `LSAT_ASSERT_IMP(a_err_zero, out_valid && out_data.range_error,
                   out_data.range_total == 64'd0, "error result carries a nonzero total")

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for range_affine_update_sum_tree_core: random and directed words
// checked against an in-bench lazy segment tree predictor.
// Depends on lsat_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
  import lsat_pkg::*;

  localparam int  TREE_NODES  = 4 * LEAVES;
  localparam longint CYCLE_LIMIT = 12_000_000;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  lsat_in_t        in_data;
  logic            out_valid;
  lsat_out_t       out_data;
  logic            cfg_we;
  logic [LC_W-1:0] cfg_wdata;

  range_affine_update_sum_tree_core u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
  end
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state.
  logic [63:0] span_sum [TREE_NODES];
  logic [63:0] lazy_add [TREE_NODES];
  logic [63:0] lazy_mul [TREE_NODES];
  int unsigned active_leaves;

  lsat_out_t expected_q[$];
  int        mismatch_count;
  longint    cycle_count;

  function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    logic signed [127:0] p;
    wa = $signed(a);
    wb = $signed(b);
    p  = wa * wb;
    return p[FRAC_BITS +: 64];
  endfunction

  function automatic void reset_tree();
    for (int i = 0; i < TREE_NODES; i++) begin
      span_sum[i] = '0;
      lazy_add[i] = '0;
      lazy_mul[i] = FIX_ONE;
    end
  endfunction

  function automatic void tag_node(int i, int l, int r, logic [63:0] f, logic [63:0] a);
    logic [63:0] len;
    if (i >= TREE_NODES) return;
    len = 64'(r - l + 1);
    span_sum[i] = q_mul(span_sum[i], f) + len * a;
    lazy_add[i] = q_mul(lazy_add[i], f) + a;
    lazy_mul[i] = q_mul(lazy_mul[i], f);
  endfunction

  function automatic void push_tags(int i, int l, int r);
    int m;
    m = (l + r) >> 1;
    if (l >= r || i >= TREE_NODES) return;
    tag_node(2 * i, l, m, lazy_mul[i], lazy_add[i]);
    tag_node(2 * i + 1, m + 1, r, lazy_mul[i], lazy_add[i]);
    lazy_mul[i] = FIX_ONE;
    lazy_add[i] = '0;
  endfunction

  function automatic void refresh_sum(int i);
    if (2 * i + 1 >= TREE_NODES) return;
    span_sum[i] = span_sum[2 * i] + span_sum[2 * i + 1];
  endfunction

  function automatic void write_leaf(int i, int l, int r, int pos, logic [63:0] v);
    int m;
    if (i >= TREE_NODES) return;
    if (l == r) begin
      span_sum[i] = v;
      lazy_add[i] = '0;
      lazy_mul[i] = FIX_ONE;
      return;
    end
    push_tags(i, l, r);
    m = (l + r) >> 1;
    if (pos <= m) write_leaf(2 * i, l, m, pos, v);
    else write_leaf(2 * i + 1, m + 1, r, pos, v);
    refresh_sum(i);
  endfunction

  function automatic void affine_range(int i, int l, int r, int ql, int qr,
                                       logic [63:0] f, logic [63:0] a);
    int m;
    if (i >= TREE_NODES) return;
    if (ql <= l && r <= qr) begin
      tag_node(i, l, r, f, a);
      return;
    end
    push_tags(i, l, r);
    m = (l + r) >> 1;
    if (ql <= m) affine_range(2 * i, l, m, ql, qr, f, a);
    if (qr > m) affine_range(2 * i + 1, m + 1, r, ql, qr, f, a);
    refresh_sum(i);
  endfunction

  function automatic logic [63:0] sum_range(int i, int l, int r, int ql, int qr);
    int m;
    logic [63:0] s;
    s = '0;
    if (i >= TREE_NODES) return '0;
    if (ql <= l && r <= qr) return span_sum[i];
    push_tags(i, l, r);
    m = (l + r) >> 1;
    if (ql <= m) s += sum_range(2 * i, l, m, ql, qr);
    if (qr > m) s += sum_range(2 * i + 1, m + 1, r, ql, qr);
    return s;
  endfunction

  function automatic lsat_out_t predict_word(lsat_in_t w);
    lsat_out_t res;
    int first, last, top;
    logic bad;
    first = w.range_first;
    last  = w.range_last;
    top   = active_leaves - 1;
    if (w.operation == OP_SET) bad = first >= active_leaves;
    else bad = first > last || last >= active_leaves;
    res.range_total = '0;
    res.range_error = bad;
    if (!bad) begin
      case (w.operation)
        OP_SET:   write_leaf(1, 0, top, first, w.operand_value);
        OP_MUL:   affine_range(1, 0, top, first, last, w.operand_value, '0);
        OP_ADD:   affine_range(1, 0, top, first, last, FIX_ONE, w.operand_value);
        default:  res.range_total = sum_range(1, 0, top, first, last);
      endcase
    end
    return res;
  endfunction

  // Hold start until taken, then predict and optionally idle.
  task automatic send_word(logic [1:0] op, int first, int last, logic [63:0] val);
    lsat_in_t w;
    int gap;
    w.operation     = op;
    w.range_first   = first[LEAF_AW-1:0];
    w.range_last    = last[LEAF_AW-1:0];
    w.operand_value = val;
    in_data <= w;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    expected_q.push_back(predict_word(w));
    gap = $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_leaf_count(int value);
    int v;
    drain();
    cfg_wdata <= value[LC_W-1:0];
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    v = value & 12'h7FF;
    if (v < 1) v = 1;
    if (v > LEAVES) v = LEAVES;
    active_leaves = v;
    reset_tree();
  endtask

  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 5))
      0:       return {$urandom, $urandom};
      1:       return FIX_ONE;
      2:       return 64'($signed($urandom_range(0, 8)) - 4) << FRAC_BITS;
      default: return 64'(longint'($signed(28'($urandom))));
    endcase
  endfunction

  task automatic test_directed();
    write_leaf_count(LEAVES);
    send_word(OP_QUERY, 0, LEAVES - 1, '0);
    send_word(OP_SET, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_word(OP_SET, LEAVES - 1, 0, 64'h8000_0000_0000_0000);
    send_word(OP_SET, 5, 1023, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(OP_QUERY, 0, LEAVES - 1, '0);
    send_word(OP_ADD, 0, LEAVES - 1, 64'h7FFF_FFFF_FFFF_FFFF);
    send_word(OP_MUL, 3, 700, 64'h8000_0000_0000_0000);
    send_word(OP_SET, 4, 0, 64'h0000_0000_0300_0000);
    send_word(OP_QUERY, 0, 0, '0);
    send_word(OP_QUERY, 4, 4, '0);
    send_word(OP_MUL, 0, LEAVES - 1, '0);
    send_word(OP_QUERY, 0, LEAVES - 1, '0);
    send_word(OP_ADD, 512, 512, FIX_ONE);
    send_word(OP_QUERY, 511, 513, '0);
    // bad ranges: reversed, and past the end after shrinking
    send_word(OP_QUERY, 9, 8, '0);
    send_word(OP_MUL, 1023, 0, FIX_ONE);
    write_leaf_count(10);
    send_word(OP_SET, 10, 0, FIX_ONE);
    send_word(OP_ADD, 0, 10, FIX_ONE);
    send_word(OP_QUERY, 0, 9, '0);
  endtask

  task automatic test_leaf_count_extremes();
    write_leaf_count(0);
    send_word(OP_SET, 0, 0, FIX_ONE);
    send_word(OP_ADD, 0, 0, FIX_ONE);
    send_word(OP_QUERY, 0, 0, '0);
    send_word(OP_SET, 1, 0, FIX_ONE);
    send_word(OP_QUERY, 0, 1, '0);
    write_leaf_count(2047);
    send_word(OP_QUERY, 0, 1023, '0);
    write_leaf_count(1);
    send_word(OP_MUL, 0, 0, FIX_ONE);
    send_word(OP_QUERY, 0, 0, '0);
  endtask

  task automatic test_random(int leaves, int count);
    int first, last;
    write_leaf_count(leaves);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) < 8) begin
        first = $urandom_range(0, active_leaves - 1);
        last  = $urandom_range(first, active_leaves - 1);
      end else begin
        first = $urandom_range(0, 1023);
        last  = $urandom_range(0, 1023);
      end
      send_word(2'($urandom_range(0, 3)), first, last, rand_operand());
    end
  endtask

  // Check each result word against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", out_data);
      end else begin
        lsat_out_t e;
        e = expected_q.pop_front();
        if (out_data.range_total !== e.range_total
            || out_data.range_error !== e.range_error) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: total exp %h got %h, error exp %b got %b",
                     e.range_total, out_data.range_total,
                     e.range_error, out_data.range_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    cycle_count    = 0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_data        = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    active_leaves  = LEAVES;
    reset_tree();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_leaf_count_extremes();
    test_random(2, 150);
    test_random(3, 150);
    test_random(17, 400);
    test_random(100, 450);
    test_random(37, 400);
    test_random(1024, 350);
    drain();
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
